[hdl/bfhw_pkg.sv]
package bfhw_pkg;

	localparam int IDX_W      = 8;    // ring index and byte counts
	localparam int SIZE_W     = 9;    // ring size register
	localparam int MAX_SIZE   = 256;  // largest usable ring
	localparam int DEPTH_DFLT = 256;

	typedef enum logic [1:0] {
		CMD_PUT      = 2'd0,
		CMD_GET      = 2'd1,
		CMD_PEAK_CLR = 2'd2,
		CMD_FLUSH    = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// ring memory access for one transaction
	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] waddr;
		logic [7:0]       wdata;
		logic             re;
		logic [IDX_W-1:0] raddr;
	} mem_req_t;

	// registered result, minus the read byte
	typedef struct packed {
		status_t          status;
		logic             get_ok;
		logic [IDX_W-1:0] fill;
		logic [IDX_W-1:0] free;
		logic [IDX_W-1:0] peak;
	} rsp_t;

endpackage

[hdl/byte_fifo_high_water.sv]
// Byte FIFO on a ring with a high-water mark.
//
// Command channel (cmd_valid / cmd_stall): command and data_byte. A
// transaction is taken on a clock edge with cmd_valid high and cmd_stall low.
// Commands: put, get, request high-water clear, flush.
// Response channel (rsp_valid / rsp_stall): one response per command with
// status, read_data, fill_count, free_space and peak_level.
// Config channel (cfg_valid / cfg_ready / cfg_data): ring size, 1..256 slots,
// clamped to DEPTH; cfg_ready is always high. Every write flushes the ring.
// Write it only while no command is in flight.
//
// The response is registered on the clock edge that takes the command.
// Throughput: one command per cycle while the receiver does not stall.
// Pointers, count and mark sit in flops, and the ring memory has one write
// port and a registered read, so a get's byte arrives along with the response.
// When the receiver stalls, the response and the read register hold and
// cmd_stall goes high until the response is taken.
// Reset: empty ring, mark zero, size 256 (or DEPTH if smaller). The ring
// memory is not cleared; a get only reads slots filled by earlier puts.
module byte_fifo_high_water #(
	parameter int DEPTH = bfhw_pkg::DEPTH_DFLT
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [bfhw_pkg::SIZE_W-1:0] cfg_data,
	input  logic                        cmd_valid,
	output logic                        cmd_stall,
	input  logic [1:0]                  command,
	input  logic [7:0]                  data_byte,
	output logic                        rsp_valid,
	input  logic                        rsp_stall,
	output logic [1:0]                  status,
	output logic [7:0]                  read_data,
	output logic [7:0]                  fill_count,
	output logic [7:0]                  free_space,
	output logic [7:0]                  peak_level
);

	// only the first MAX_SIZE slots can ever be addressed
	localparam int MEM_DEPTH = (DEPTH < bfhw_pkg::MAX_SIZE) ? DEPTH : bfhw_pkg::MAX_SIZE;

	logic               accept;
	logic               rsp_valid_q;
	logic [7:0]         rdata_q;
	bfhw_pkg::mem_req_t mem_req;
	bfhw_pkg::rsp_t     rsp_s1;

	assign cfg_ready = 1'b1;
	// single response slot: take a new command when the slot frees up
	assign cmd_stall = rsp_valid_q && rsp_stall;
	assign accept    = cmd_valid && !cmd_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (accept) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	bfhw_ctrl #(
		.MEM_DEPTH(MEM_DEPTH)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg_we  (cfg_valid && cfg_ready),
		.cfg_size(cfg_data),
		.accept  (accept),
		.cmd     (bfhw_pkg::cmd_t'(command)),
		.wbyte   (data_byte),
		.mem_req (mem_req),
		.rsp_s1  (rsp_s1)
	);

	bfhw_ring_mem #(
		.MEM_DEPTH(MEM_DEPTH)
	) u_mem (
		.clk    (clk),
		.req    (mem_req),
		.rdata_q(rdata_q)
	);

	assign rsp_valid  = rsp_valid_q;
	assign status     = rsp_s1.status;
	assign read_data  = rsp_s1.get_ok ? rdata_q : 8'd0;
	assign fill_count = rsp_s1.fill;
	assign free_space = rsp_s1.free;
	assign peak_level = rsp_s1.peak;

	// a failed get means the ring was empty
	a_empty_fill: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_s1.status == bfhw_pkg::ST_EMPTY |-> rsp_s1.fill == '0)
		else $error("get reported empty with bytes held");

	// a failed put means no free slot was left
	a_full_free: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_s1.status == bfhw_pkg::ST_FULL |-> rsp_s1.free == '0)
		else $error("put reported full with free space");

	// read register must not reload while a response waits
	a_rdata_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_stall |=> $stable(read_data))
		else $error("read data changed under stall");

	// memory is only read for a taken get
	a_read_on_get: assert property (@(posedge clk) disable iff (!arst_n)
		mem_req.re |-> accept && command == bfhw_pkg::CMD_GET)
		else $error("ring read without a get");

endmodule

[hdl/bfhw_ring_mem.sv]
module bfhw_ring_mem #(
	parameter int MEM_DEPTH = bfhw_pkg::DEPTH_DFLT
) (
	input  logic               clk,
	input  bfhw_pkg::mem_req_t req,
	output logic [7:0]         rdata_q
);

	localparam int AW = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

	logic [7:0] ring_store [MEM_DEPTH];

	always_ff @(posedge clk) begin
		if (req.we) begin
			ring_store[req.waddr[AW-1:0]] <= req.wdata;
		end
		// read register holds while no get is taken
		if (req.re) begin
			rdata_q <= ring_store[req.raddr[AW-1:0]];
		end
	end

endmodule

[hdl/bfhw_ctrl.sv]
module bfhw_ctrl #(
	parameter int MEM_DEPTH = bfhw_pkg::DEPTH_DFLT
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [bfhw_pkg::SIZE_W-1:0] cfg_size,
	input  logic                        accept,
	input  bfhw_pkg::cmd_t              cmd,
	input  logic [7:0]                  wbyte,
	output bfhw_pkg::mem_req_t          mem_req,
	output bfhw_pkg::rsp_t              rsp_s1
);

	localparam int IW = bfhw_pkg::IDX_W;
	localparam int SW = bfhw_pkg::SIZE_W;
	localparam logic [SW-1:0] SIZE_LIM = SW'(MEM_DEPTH);

	logic [SW-1:0] size_q;
	logic [IW-1:0] rd_q, wr_q, held_q, peak_q;
	logic          pend_q;

	logic [SW-1:0] wr_inc, rd_inc, free_w;
	logic [IW-1:0] wr_nxt, rd_nxt, held_nxt, peak_nxt;
	logic          pend_nxt, put_ok, get_ok;
	bfhw_pkg::status_t status_nxt;

	always_comb begin
		wr_inc     = {1'b0, wr_q} + SW'(1);
		rd_inc     = {1'b0, rd_q} + SW'(1);
		wr_nxt     = (wr_inc == size_q) ? '0 : wr_inc[IW-1:0];
		rd_nxt     = (rd_inc == size_q) ? '0 : rd_inc[IW-1:0];
		put_ok     = 1'b0;
		get_ok     = 1'b0;
		status_nxt = bfhw_pkg::ST_OK;
		held_nxt   = held_q;
		peak_nxt   = peak_q;
		pend_nxt   = pend_q;
		case (cmd)
			bfhw_pkg::CMD_PUT: begin
				if (wr_nxt != rd_q) begin
					put_ok   = 1'b1;
					held_nxt = held_q + IW'(1);
					if (held_nxt > peak_q && !pend_q) begin
						peak_nxt = held_nxt;
					end
				end else begin
					status_nxt = bfhw_pkg::ST_FULL;
				end
			end
			bfhw_pkg::CMD_GET: begin
				if (rd_q != wr_q) begin
					get_ok = 1'b1;
					if (held_q != '0) begin
						held_nxt = held_q - IW'(1);
					end
					// draining the ring completes a pending mark clear
					if (pend_q && held_nxt == '0) begin
						peak_nxt = '0;
						pend_nxt = 1'b0;
					end
				end else begin
					status_nxt = bfhw_pkg::ST_EMPTY;
				end
			end
			bfhw_pkg::CMD_PEAK_CLR: begin
				pend_nxt = 1'b1;
			end
			default: begin
				held_nxt = '0;
				peak_nxt = '0;
				pend_nxt = 1'b0;
			end
		endcase
		// count never exceeds size - 1
		free_w = size_q - SW'(1) - {1'b0, held_nxt};
	end

	assign mem_req.we    = accept && put_ok;
	assign mem_req.waddr = wr_q;
	assign mem_req.wdata = wbyte;
	assign mem_req.re    = accept && get_ok;
	assign mem_req.raddr = rd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= SIZE_LIM;
			rd_q   <= '0;
			wr_q   <= '0;
			held_q <= '0;
			peak_q <= '0;
			pend_q <= 1'b0;
		end else if (cfg_we) begin
			// clamp to 1..MEM_DEPTH and flush
			if (cfg_size == '0) begin
				size_q <= SW'(1);
			end else if (cfg_size > SIZE_LIM) begin
				size_q <= SIZE_LIM;
			end else begin
				size_q <= cfg_size;
			end
			rd_q   <= '0;
			wr_q   <= '0;
			held_q <= '0;
			peak_q <= '0;
			pend_q <= 1'b0;
		end else if (accept) begin
			if (put_ok) begin
				wr_q <= wr_nxt;
			end
			if (get_ok) begin
				rd_q <= rd_nxt;
			end
			if (cmd == bfhw_pkg::CMD_FLUSH) begin
				rd_q <= '0;
				wr_q <= '0;
			end
			held_q <= held_nxt;
			peak_q <= peak_nxt;
			pend_q <= pend_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_s1.status <= status_nxt;
			rsp_s1.get_ok <= get_ok;
			rsp_s1.fill   <= held_nxt;
			rsp_s1.free   <= free_w[IW-1:0];
			rsp_s1.peak   <= peak_nxt;
		end
	end

endmodule

[tb/byte_fifo_high_water_tb.sv]
`timescale 1ns / 100ps

module byte_fifo_high_water_tb;

	localparam int GAP_MAX   = 17;   // longest random idle burst, either side
	localparam int LONG_HOLD = 200;  // receiver back-pressure stretch, in cycles
	localparam int N_PHASES  = 10;

	// One expected response, at the widths of the response ports.
	typedef struct {
		bfhw_pkg::status_t status;
		logic [7:0]        read_data;
		logic [7:0]        fill;
		logic [7:0]        free;
		logic [7:0]        peak;
	} fifo_rsp_t;

	// Mirror of the ring: tracks pointers, count and high-water mark for every
	// accepted command and keeps the responses still owed by the block.
	class ring_mirror;
		logic [7:0] ring [0:255];
		logic [7:0] rd_ptr;
		logic [7:0] wr_ptr;
		logic [7:0] held;
		logic [7:0] peak;
		bit         clr_pending;
		logic [8:0] size_reg;
		fifo_rsp_t  owed_q[$];
		int         mismatches;
		int         n_cmd[4];
		int         full_puts;
		int         empty_gets;
		int         top_fill;

		function new();
			size_reg = 9'd256;
			flush();
		endfunction

		function void flush();
			rd_ptr      = '0;
			wr_ptr      = '0;
			held        = '0;
			peak        = '0;
			clr_pending = 1'b0;
		endfunction

		// a size write always flushes the ring
		function void set_size(logic [8:0] v);
			size_reg = v;
			flush();
		endfunction

		// register value limited to 1..256
		function int unsigned usable_size();
			if (size_reg == 0)
				return 1;
			if (size_reg > bfhw_pkg::MAX_SIZE)
				return bfhw_pkg::MAX_SIZE;
			return size_reg;
		endfunction

		function int outstanding();
			return owed_q.size();
		endfunction

		function void take_command(bfhw_pkg::cmd_t c, logic [7:0] b);
			fifo_rsp_t   r;
			int unsigned eff;
			int unsigned nxt;
			eff         = usable_size();
			r.status    = bfhw_pkg::ST_OK;
			r.read_data = 8'h00;
			case (c)
				bfhw_pkg::CMD_PUT: begin
					nxt = (wr_ptr + 1) % eff;
					if (nxt != rd_ptr) begin
						ring[wr_ptr] = b;
						wr_ptr       = nxt[7:0];
						held         = held + 8'd1;
						if (held > peak && !clr_pending)
							peak = held;
						if (held > top_fill)
							top_fill = held;
					end else begin
						r.status = bfhw_pkg::ST_FULL;
						full_puts++;
					end
				end
				bfhw_pkg::CMD_GET: begin
					if (rd_ptr != wr_ptr) begin
						r.read_data = ring[rd_ptr];
						nxt         = (rd_ptr + 1) % eff;
						rd_ptr      = nxt[7:0];
						if (held > 0)
							held = held - 8'd1;
						if (clr_pending && held == 0) begin
							peak        = '0;
							clr_pending = 1'b0;
						end
					end else begin
						r.status = bfhw_pkg::ST_EMPTY;
						empty_gets++;
					end
				end
				bfhw_pkg::CMD_PEAK_CLR: clr_pending = 1'b1;
				default:                flush();
			endcase
			n_cmd[int'(c)]++;
			r.fill = held;
			r.free = (eff >= held + 1) ? 8'(eff - held - 1) : 8'd0;
			r.peak = peak;
			owed_q.push_back(r);
		endfunction

		function void compare_field(string name, int unsigned want, int unsigned got);
			if (want != got) begin
				$display("[%0t] %s mismatch: expected %0d, actual %0d", $time, name, want, got);
				mismatches++;
			end
		endfunction

		function void check_response(logic [1:0] st, logic [7:0] rdat, fill, free, hw);
			fifo_rsp_t e;
			if (owed_q.size() == 0) begin
				$display({"[%0t] response with no command pending: ",
					"expected none, actual status %0d fill %0d"}, $time, st, fill);
				mismatches++;
				return;
			end
			e = owed_q.pop_front();
			compare_field("status", e.status, st);
			compare_field("read_data", e.read_data, rdat);
			compare_field("fill_count", e.fill, fill);
			compare_field("free_space", e.free, free);
			compare_field("peak_level", e.peak, hw);
		endfunction
	endclass

	// ------------------------------------------------------------------
	// Block ports. Every input starts at a known value.
	// ------------------------------------------------------------------
	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [8:0] cfg_data  = '0;
	logic       cmd_valid = 1'b0;
	logic       cmd_stall;
	logic [1:0] command   = bfhw_pkg::CMD_PUT;
	logic [7:0] data_byte = '0;
	logic       rsp_valid;
	logic       rsp_stall = 1'b0;
	logic [1:0] status;
	logic [7:0] read_data;
	logic [7:0] fill_count;
	logic [7:0] free_space;
	logic [7:0] peak_level;

	ring_mirror mirror = new();

	// idle controls, changed per phase by the main sequence
	bit cmd_idle_on   = 1'b1;
	bit rsp_idle_on   = 1'b1;
	bit hold_off_req  = 1'b0;
	int long_holds    = 0;
	int sizes_written = 0;

	byte_fifo_high_water dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.cmd_valid  (cmd_valid),
		.cmd_stall  (cmd_stall),
		.command    (command),
		.data_byte  (data_byte),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.status     (status),
		.read_data  (read_data),
		.fill_count (fill_count),
		.free_space (free_space),
		.peak_level (peak_level)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 0;
	end

	// Hard stop in case the block hangs a handshake.
	initial begin
		#2_000_000;
		$display("** byte_fifo_high_water: FAILED **");
		$finish;
	end

	// ------------------------------------------------------------------
	// Monitor: sample both channels on the clock edge. All drives are
	// nonblocking at the edge, so this sees the settled pre-edge values.
	// A command accepted on this edge is logged before any response is
	// checked, so the queue order always matches the block's order.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (cmd_valid && !cmd_stall)
				mirror.take_command(bfhw_pkg::cmd_t'(command), data_byte);
			if (rsp_valid && !rsp_stall)
				mirror.check_response(status, read_data, fill_count, free_space, peak_level);
		end
	end

	// ------------------------------------------------------------------
	// Receiver: random stall bursts, plus one long hold on request. The
	// long hold is counted here so the sender keeps offering commands and
	// the block backs up into cmd_stall.
	// ------------------------------------------------------------------
	initial begin
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				rsp_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
				rsp_stall    <= 1'b0;
				hold_off_req = 1'b0;
				long_holds++;
			end else if (rsp_idle_on && $urandom_range(0, 5) == 0) begin
				rsp_stall <= 1'b1;
				repeat ($urandom_range(1, GAP_MAX)) @(posedge clk);
				rsp_stall <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Sender. Called at a clock edge; returns at the edge where the
	// transaction was taken. A gap lowers valid once; otherwise valid
	// stays high from one transaction to the next.
	// ------------------------------------------------------------------
	task automatic issue_command(bfhw_pkg::cmd_t c, logic [7:0] b);
		if (cmd_idle_on && $urandom_range(0, 5) == 0) begin
			cmd_valid <= 1'b0;
			repeat ($urandom_range(1, GAP_MAX)) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		command   <= c;
		data_byte <= b;
		@(posedge clk);
		while (cmd_stall) @(posedge clk);
	endtask

	// Stop sending and wait until every owed response has come back.
	// The first edge lets the monitor log a command taken on the edge we
	// were called at.
	task automatic drain_responses();
		cmd_valid <= 1'b0;
		@(posedge clk);
		while (mirror.outstanding() != 0) @(posedge clk);
	endtask

	// Size write only with the block idle and every response taken.
	task automatic write_ring_size(logic [8:0] v);
		drain_responses();
		repeat (2) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		mirror.set_size(v);
		sizes_written++;
	endtask

	// Command mix. A clean burst runs one way with only the odd mark-clear
	// request mixed in, so the ring really reaches full or empty. A mixed
	// burst leans one way but also throws in the other direction, requests
	// and flushes.
	function automatic bfhw_pkg::cmd_t pick_command(bit filling, bit clean);
		int unsigned    r;
		bfhw_pkg::cmd_t lead;
		bfhw_pkg::cmd_t other;
		r     = $urandom_range(0, 99);
		lead  = filling ? bfhw_pkg::CMD_PUT : bfhw_pkg::CMD_GET;
		other = filling ? bfhw_pkg::CMD_GET : bfhw_pkg::CMD_PUT;
		if (r < 5)
			return bfhw_pkg::CMD_PEAK_CLR;
		if (clean)
			return lead;
		if (r < 8)
			return bfhw_pkg::CMD_FLUSH;
		if (r < 25)
			return other;
		return lead;
	endfunction

	// One random phase at the current size. The first burst fills past full
	// where the phase budget allows; later bursts pick a direction and length
	// at random, a quarter of them long enough to run past full or empty.
	task automatic run_phase(int budget);
		int          issued;
		int          burst;
		int          k;
		bit          filling;
		bit          clean;
		int unsigned eff;
		issued = 0;
		while (issued < budget) begin
			eff = mirror.usable_size();
			if (issued == 0 || $urandom_range(0, 3) == 0) begin
				filling = (issued == 0) ? 1'b1 : 1'($urandom_range(0, 1));
				clean   = 1'b1;
				burst   = eff + eff / 8 + 3;
			end else begin
				filling = 1'($urandom_range(0, 1));
				clean   = 1'b0;
				burst   = $urandom_range(1, eff + 2);
			end
			if (burst > budget - issued)
				burst = budget - issued;
			for (k = 0; k < burst; k++)
				issue_command(pick_command(filling, clean), 8'($urandom_range(0, 255)));
			issued += burst;
		end
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		logic [8:0] phase_size [N_PHASES];
		int         phase_budget [N_PHASES];
		int         p;

		// sizes: default, smallest working, register all-ones, zero (acts
		// as one), tiny, just past the top, one (never holds), odd, random,
		// and the full ring again with no idling at all
		phase_size   = '{9'd256, 9'd2, 9'd511, 9'd0, 9'd3, 9'd257, 9'd1, 9'd9, 9'd0, 9'd256};
		phase_budget = '{300, 20, 20, 10, 20, 20, 10, 30, 20, 20};
		phase_size[8] = 9'($urandom_range(4, 200));

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed part, ring size 256 out of reset ---
		issue_command(bfhw_pkg::CMD_GET, 8'h00);       // get on empty ring
		issue_command(bfhw_pkg::CMD_PUT, 8'h00);
		issue_command(bfhw_pkg::CMD_PUT, 8'hFF);
		issue_command(bfhw_pkg::CMD_PUT, 8'h5A);       // mark at 3
		issue_command(bfhw_pkg::CMD_PEAK_CLR, 8'hFF);  // freeze mark
		issue_command(bfhw_pkg::CMD_PUT, 8'h81);       // count 4, mark held at 3
		issue_command(bfhw_pkg::CMD_GET, 8'h00);
		issue_command(bfhw_pkg::CMD_GET, 8'h00);
		issue_command(bfhw_pkg::CMD_GET, 8'h00);
		issue_command(bfhw_pkg::CMD_GET, 8'h00);       // drains: mark cleared, request dropped
		issue_command(bfhw_pkg::CMD_GET, 8'h00);
		issue_command(bfhw_pkg::CMD_PEAK_CLR, 8'h00);  // request while empty stays pending
		issue_command(bfhw_pkg::CMD_PUT, 8'h01);       // mark stays frozen at zero
		issue_command(bfhw_pkg::CMD_PUT, 8'h02);
		issue_command(bfhw_pkg::CMD_FLUSH, 8'hFF);     // clears request too
		issue_command(bfhw_pkg::CMD_PUT, 8'h7E);       // mark tracks again

		// zero acts as one slot: nothing fits
		write_ring_size(9'd0);
		issue_command(bfhw_pkg::CMD_PUT, 8'h33);
		issue_command(bfhw_pkg::CMD_GET, 8'h00);

		// two slots: exactly one byte fits
		write_ring_size(9'd2);
		issue_command(bfhw_pkg::CMD_PUT, 8'hC3);
		issue_command(bfhw_pkg::CMD_PUT, 8'h3C);
		issue_command(bfhw_pkg::CMD_GET, 8'h00);
		issue_command(bfhw_pkg::CMD_GET, 8'h00);
		issue_command(bfhw_pkg::CMD_FLUSH, 8'h00);

		// --- random phases ---
		for (p = 0; p < N_PHASES; p++) begin
			write_ring_size(phase_size[p]);
			cmd_idle_on = (p % 3) != 2;
			rsp_idle_on = (p % 4) != 3;
			if (p == N_PHASES - 1) begin
				cmd_idle_on = 1'b0;
				rsp_idle_on = 1'b0;
			end
			if (p == 7)
				hold_off_req = 1'b1;  // receiver backs off while we keep sending
			run_phase(phase_budget[p]);
		end

		drain_responses();
		repeat (5) @(posedge clk);

		$display("Summary: %0d transactions (put %0d, get %0d, mark clear %0d, flush %0d),",
			mirror.n_cmd[0] + mirror.n_cmd[1] + mirror.n_cmd[2] + mirror.n_cmd[3],
			mirror.n_cmd[bfhw_pkg::CMD_PUT], mirror.n_cmd[bfhw_pkg::CMD_GET],
			mirror.n_cmd[bfhw_pkg::CMD_PEAK_CLR], mirror.n_cmd[bfhw_pkg::CMD_FLUSH]);
		$display({"Summary: %0d size writes, %0d puts on full ring, %0d gets on empty ring, ",
			"deepest fill %0d, %0d long hold(s)"},
			sizes_written, mirror.full_puts, mirror.empty_gets, mirror.top_fill, long_holds);

		if (mirror.mismatches == 0)
			$display("** byte_fifo_high_water: PASSED **");
		else
			$display("** byte_fifo_high_water: FAILED **");
		$finish;
	end

endmodule

[sim.f]
hdl/bfhw_pkg.sv
hdl/bfhw_ring_mem.sv
hdl/bfhw_ctrl.sv
hdl/byte_fifo_high_water.sv
tb/byte_fifo_high_water_tb.sv
